// ----- rtl/core/vector_record_bitfield_parser_unit_assert.svh -----
`ifndef VECTOR_RECORD_BITFIELD_PARSER_UNIT_ASSERT_SVH
`define VECTOR_RECORD_BITFIELD_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define VRBP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define VRBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define VRBP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define VRBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- rtl/core/vrbp_pkg.sv -----
package vrbp_pkg;

	localparam int DATA_W = 8;
	localparam int MODE_W = 3;
	localparam int ID_W = 5;
	localparam int VAL_W = 31;
	localparam int CFG_IDX_W = 2;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W = $clog2(MAX_RESULTS + 1);

	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ROTATE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MULTIPLY = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ADD = 2'd3;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic progress;
		logic emit;
	} sts_t;

endpackage

// ----- rtl/core/vrbp_if.sv -----
interface vrbp_in_if;
	logic valid;
	logic ready;
	logic [vrbp_pkg::DATA_W-1:0] data_byte;
	logic [vrbp_pkg::MODE_W-1:0] mode;

	modport source (output valid, data_byte, mode, input ready);
	modport sink (input valid, data_byte, mode, output ready);
endinterface

interface vrbp_out_if;
	logic valid;
	logic ready;
	logic [vrbp_pkg::ID_W-1:0] field_id;
	logic signed [vrbp_pkg::VAL_W-1:0] field_value;
	logic record_last;

	modport source (output valid, field_id, field_value, record_last, input ready);
	modport sink (input valid, field_id, field_value, record_last, output ready);
endinterface

interface vrbp_cfg_if;
	logic valid;
	logic ready;
	logic [vrbp_pkg::CFG_IDX_W-1:0] index;
	logic signed [vrbp_pkg::VAL_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/vrbp_datapath.sv -----
module vrbp_datapath #(
	parameter int RECT_COUNT_BITS = 5,
	parameter int SCALE_COUNT_BITS = 5,
	parameter int ROTATE_COUNT_BITS = 5,
	parameter int TRANSLATE_COUNT_BITS = 5,
	parameter int COLOUR_COUNT_BITS = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  vrbp_pkg::cmd_t cmd,
	output vrbp_pkg::sts_t sts,
	input  logic [vrbp_pkg::DATA_W-1:0] data_byte,
	input  logic [vrbp_pkg::MODE_W-1:0] mode,
	input  logic cfg_we,
	input  logic [vrbp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic signed [vrbp_pkg::VAL_W-1:0] cfg_data,
	output logic [vrbp_pkg::ID_W-1:0] field_id,
	output logic signed [vrbp_pkg::VAL_W-1:0] field_value,
	output logic record_last
);
	import vrbp_pkg::*;

	localparam int BUF_W = 40;
	localparam int HELD_W = 6;
	localparam int STEP_W = 5;
	localparam int FW_W = 5;

	localparam logic [MODE_W-1:0] KIND_RECT = 3'd0;
	localparam logic [MODE_W-1:0] KIND_MATRIX = 3'd1;
	localparam logic [MODE_W-1:0] KIND_CX = 3'd2;
	localparam logic [MODE_W-1:0] KIND_CXA = 3'd3;
	localparam logic [MODE_W-1:0] KIND_RGB = 3'd4;
	localparam logic [MODE_W-1:0] KIND_RGBA = 3'd5;

	localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
	localparam logic [STEP_W-1:0] STEP_FIRST = 5'd1;

	localparam logic [STEP_W-1:0] RC_CNT = 5'd1;
	localparam logic [STEP_W-1:0] RC_X0 = 5'd2;
	localparam logic [STEP_W-1:0] RC_Y1 = 5'd5;

	localparam logic [STEP_W-1:0] MX_SCALE_FLAG = 5'd1;
	localparam logic [STEP_W-1:0] MX_SCALE_CNT = 5'd2;
	localparam logic [STEP_W-1:0] MX_SX = 5'd3;
	localparam logic [STEP_W-1:0] MX_SY = 5'd4;
	localparam logic [STEP_W-1:0] MX_ROT_FLAG = 5'd5;
	localparam logic [STEP_W-1:0] MX_ROT_CNT = 5'd6;
	localparam logic [STEP_W-1:0] MX_R0 = 5'd7;
	localparam logic [STEP_W-1:0] MX_R1 = 5'd8;
	localparam logic [STEP_W-1:0] MX_TR_CNT = 5'd9;
	localparam logic [STEP_W-1:0] MX_TX = 5'd10;
	localparam logic [STEP_W-1:0] MX_TY = 5'd11;
	localparam logic [STEP_W-1:0] MX_DEF_SX = 5'd12;
	localparam logic [STEP_W-1:0] MX_DEF_SY = 5'd13;
	localparam logic [STEP_W-1:0] MX_DEF_R0 = 5'd14;
	localparam logic [STEP_W-1:0] MX_DEF_R1 = 5'd15;

	localparam logic [STEP_W-1:0] CX_FLAGS = 5'd1;
	localparam logic [STEP_W-1:0] CX_CNT = 5'd2;
	localparam logic [STEP_W-1:0] CX_MR = 5'd3;
	localparam logic [STEP_W-1:0] CX_MA = 5'd6;
	localparam logic [STEP_W-1:0] CX_AR = 5'd7;
	localparam logic [STEP_W-1:0] CX_AA = 5'd10;
	localparam logic [STEP_W-1:0] CX_FID_OFS = 5'd7;

	localparam logic [STEP_W-1:0] RGB_FIRST = 5'd1;
	localparam logic [STEP_W-1:0] RGB_LAST3 = 5'd3;
	localparam logic [STEP_W-1:0] RGB_LAST4 = 5'd4;
	localparam logic [STEP_W-1:0] RGB_FID_OFS = 5'd17;

	localparam logic [ID_W-1:0] FID_SX = 5'd4;
	localparam logic [ID_W-1:0] FID_SY = 5'd5;
	localparam logic [ID_W-1:0] FID_R0 = 5'd6;
	localparam logic [ID_W-1:0] FID_R1 = 5'd7;
	localparam logic [ID_W-1:0] FID_TX = 5'd8;
	localparam logic [ID_W-1:0] FID_TY = 5'd9;

	localparam logic [HELD_W-1:0] BYTE_BITS = HELD_W'(DATA_W);
	localparam logic [HELD_W-1:0] CXFLAG_BITS = 6'd2;
	localparam logic [HELD_W-1:0] FLAG_BITS = 6'd1;

	typedef enum logic [2:0] {
		ACT_BAD,
		ACT_WIDTH,
		ACT_FLAG,
		ACT_CXFLAGS,
		ACT_READ,
		ACT_GIVE
	} act_t;

	logic [BUF_W-1:0] buf_q;
	logic [HELD_W-1:0] held_q;
	logic [STEP_W-1:0] step_q;
	logic [FW_W-1:0] width_q;
	logic [MODE_W-1:0] kind_q;
	logic has_mul_q;
	logic has_add_q;
	logic signed [VAL_W-1:0] def_scale_q;
	logic signed [VAL_W-1:0] def_rotate_q;
	logic signed [VAL_W-1:0] def_mul_q;
	logic signed [VAL_W-1:0] def_add_q;
	logic [ID_W-1:0] fid_q;
	logic signed [VAL_W-1:0] fval_q;
	logic flast_q;

	act_t act;
	logic [HELD_W-1:0] take_w;
	logic [ID_W-1:0] act_id;
	logic act_last;
	logic act_signed;
	logic [STEP_W-1:0] act_next;
	logic [STEP_W-1:0] act_alt;
	logic signed [VAL_W-1:0] act_dflt;
	logic cx_grp;

	logic ok;
	logic [BUF_W-1:0] shifted;
	logic [31:0] take_mask;
	logic [VAL_W-1:0] raw;
	logic sign_bit;
	logic [VAL_W-1:0] read_val;
	logic [HELD_W-1:0] held_left;
	logic [BUF_W:0] keep_mask;
	logic [BUF_W-1:0] buf_left;

	logic start;
	logic [BUF_W-1:0] load_base;
	logic [HELD_W-1:0] held_base;
	logic [HELD_W:0] held_sum;

	always_comb begin
		act = ACT_BAD;
		take_w = '0;
		act_id = '0;
		act_last = 1'b0;
		act_signed = 1'b1;
		act_next = STEP_IDLE;
		act_alt = STEP_IDLE;
		act_dflt = '0;
		cx_grp = 1'b0;
		case (kind_q)
			KIND_RECT: begin
				if (step_q == RC_CNT) begin
					act = ACT_WIDTH;
					take_w = HELD_W'(RECT_COUNT_BITS);
					act_next = RC_X0;
				end else if (step_q >= RC_X0 && step_q <= RC_Y1) begin
					act = ACT_READ;
					take_w = HELD_W'(width_q);
					act_id = ID_W'(step_q - RC_X0);
					act_last = (step_q == RC_Y1);
					act_next = step_q + 5'd1;
				end
			end
			KIND_MATRIX: begin
				case (step_q)
					MX_SCALE_FLAG: begin
						act = ACT_FLAG;
						take_w = FLAG_BITS;
						act_next = MX_SCALE_CNT;
						act_alt = MX_DEF_SX;
					end
					MX_SCALE_CNT: begin
						act = ACT_WIDTH;
						take_w = HELD_W'(SCALE_COUNT_BITS);
						act_next = MX_SX;
					end
					MX_SX: begin
						act = ACT_READ;
						take_w = HELD_W'(width_q);
						act_id = FID_SX;
						act_next = MX_SY;
					end
					MX_SY: begin
						act = ACT_READ;
						take_w = HELD_W'(width_q);
						act_id = FID_SY;
						act_next = MX_ROT_FLAG;
					end
					MX_ROT_FLAG: begin
						act = ACT_FLAG;
						take_w = FLAG_BITS;
						act_next = MX_ROT_CNT;
						act_alt = MX_DEF_R0;
					end
					MX_ROT_CNT: begin
						act = ACT_WIDTH;
						take_w = HELD_W'(ROTATE_COUNT_BITS);
						act_next = MX_R0;
					end
					MX_R0: begin
						act = ACT_READ;
						take_w = HELD_W'(width_q);
						act_id = FID_R0;
						act_next = MX_R1;
					end
					MX_R1: begin
						act = ACT_READ;
						take_w = HELD_W'(width_q);
						act_id = FID_R1;
						act_next = MX_TR_CNT;
					end
					MX_TR_CNT: begin
						act = ACT_WIDTH;
						take_w = HELD_W'(TRANSLATE_COUNT_BITS);
						act_next = MX_TX;
					end
					MX_TX: begin
						act = ACT_READ;
						take_w = HELD_W'(width_q);
						act_id = FID_TX;
						act_next = MX_TY;
					end
					MX_TY: begin
						act = ACT_READ;
						take_w = HELD_W'(width_q);
						act_id = FID_TY;
						act_last = 1'b1;
					end
					MX_DEF_SX: begin
						act = ACT_GIVE;
						act_id = FID_SX;
						act_dflt = def_scale_q;
						act_next = MX_DEF_SY;
					end
					MX_DEF_SY: begin
						act = ACT_GIVE;
						act_id = FID_SY;
						act_dflt = def_scale_q;
						act_next = MX_ROT_FLAG;
					end
					MX_DEF_R0: begin
						act = ACT_GIVE;
						act_id = FID_R0;
						act_dflt = def_rotate_q;
						act_next = MX_DEF_R1;
					end
					MX_DEF_R1: begin
						act = ACT_GIVE;
						act_id = FID_R1;
						act_dflt = def_rotate_q;
						act_next = MX_TR_CNT;
					end
					default: begin
						act = ACT_BAD;
					end
				endcase
			end
			KIND_CX, KIND_CXA: begin
				if (step_q == CX_FLAGS) begin
					act = ACT_CXFLAGS;
					take_w = CXFLAG_BITS;
					act_next = CX_CNT;
				end else if (step_q == CX_CNT) begin
					act = ACT_WIDTH;
					take_w = HELD_W'(COLOUR_COUNT_BITS);
					act_next = CX_MR;
				end else if (step_q >= CX_MR && step_q <= CX_AA) begin
					cx_grp = (step_q < CX_AR) ? has_mul_q : has_add_q;
					act_id = ID_W'(step_q + CX_FID_OFS);
					act_last = (step_q == CX_AA);
					act_next = step_q + 5'd1;
					act_dflt = (step_q < CX_AR) ? def_mul_q : def_add_q;
					if (cx_grp && (!(step_q == CX_MA || step_q == CX_AA)
							|| kind_q == KIND_CXA)) begin
						act = ACT_READ;
						take_w = HELD_W'(width_q);
					end else begin
						act = ACT_GIVE;
					end
				end
			end
			KIND_RGB, KIND_RGBA: begin
				if (step_q >= RGB_FIRST
					&& step_q <= ((kind_q == KIND_RGBA) ? RGB_LAST4 : RGB_LAST3)) begin
					act = ACT_READ;
					take_w = BYTE_BITS;
					act_signed = 1'b0;
					act_id = ID_W'(step_q + RGB_FID_OFS);
					act_last = (step_q == ((kind_q == KIND_RGBA) ? RGB_LAST4 : RGB_LAST3));
					act_next = step_q + 5'd1;
				end
			end
			default: begin
				act = ACT_BAD;
			end
		endcase
	end

	assign ok = (held_q >= take_w);
	assign shifted = buf_q >> (held_q - take_w);
	assign take_mask = (32'd1 << take_w) - 32'd1;
	assign raw = shifted[VAL_W-1:0] & take_mask[VAL_W-1:0];
	assign sign_bit = |(raw & (take_mask[VAL_W-1:0] ^ (take_mask[VAL_W-1:0] >> 1)));
	assign read_val = (act_signed && sign_bit) ? (raw | ~take_mask[VAL_W-1:0]) : raw;
	assign held_left = held_q - take_w;
	assign keep_mask = ((BUF_W+1)'(1) << held_left) - (BUF_W+1)'(1);
	assign buf_left = buf_q & keep_mask[BUF_W-1:0];

	assign sts.busy = (step_q != STEP_IDLE);
	assign sts.progress = (act != ACT_BAD) && ok;
	assign sts.emit = (act == ACT_READ || act == ACT_GIVE) && ok;

	assign start = (step_q == STEP_IDLE);
	assign load_base = start ? '0 : buf_q;
	assign held_base = start ? '0 : held_q;
	assign held_sum = {1'b0, held_base} + {1'b0, BYTE_BITS};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			held_q <= '0;
			step_q <= STEP_IDLE;
			width_q <= '0;
			kind_q <= KIND_RECT;
			has_mul_q <= 1'b0;
			has_add_q <= 1'b0;
		end else if (cmd.load) begin
			if (!start || mode <= KIND_RGBA) begin
				if (start) begin
					kind_q <= mode;
					step_q <= STEP_FIRST;
					width_q <= '0;
					has_mul_q <= 1'b0;
					has_add_q <= 1'b0;
				end
				buf_q <= {load_base[BUF_W-DATA_W-1:0], data_byte};
				held_q <= (held_sum > (HELD_W+1)'(BUF_W)) ? HELD_W'(BUF_W) : held_sum[HELD_W-1:0];
			end
		end else if (cmd.step) begin
			if (act == ACT_BAD) begin
				step_q <= STEP_IDLE;
				buf_q <= '0;
				held_q <= '0;
			end else if (ok) begin
				buf_q <= buf_left;
				held_q <= held_left;
				case (act)
					ACT_WIDTH: begin
						width_q <= raw[FW_W-1:0];
						step_q <= act_next;
					end
					ACT_FLAG: begin
						step_q <= raw[0] ? act_next : act_alt;
					end
					ACT_CXFLAGS: begin
						has_add_q <= raw[1];
						has_mul_q <= raw[0];
						step_q <= act_next;
					end
					default: begin
						if (act_last) begin
							step_q <= STEP_IDLE;
							buf_q <= '0;
							held_q <= '0;
						end else begin
							step_q <= act_next;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_scale_q <= 31'sd65536;
			def_rotate_q <= '0;
			def_mul_q <= 31'sd256;
			def_add_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEFAULT_SCALE: def_scale_q <= cfg_data;
				REG_DEFAULT_ROTATE: def_rotate_q <= cfg_data;
				REG_DEFAULT_MULTIPLY: def_mul_q <= cfg_data;
				REG_DEFAULT_ADD: def_add_q <= cfg_data;
				default: def_add_q <= def_add_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && sts.emit) begin
			fid_q <= act_id;
			fval_q <= (act == ACT_READ) ? signed'(read_val) : act_dflt;
			flast_q <= act_last;
		end
	end

	assign field_id = fid_q;
	assign field_value = fval_q;
	assign record_last = flast_q;

endmodule

// ----- rtl/core/vrbp_ctrl.sv -----
`include "vector_record_bitfield_parser_unit_assert.svh"

module vrbp_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output vrbp_pkg::cmd_t cmd,
	input  vrbp_pkg::sts_t sts
);
	import vrbp_pkg::*;

	state_t state_q;
	state_t state_d;
	logic [CNT_W-1:0] cnt_q;
	logic out_valid_q;
	logic slot_free;
	logic cap_hit;

	assign slot_free = !out_valid_q || out_ready;
	assign cap_hit = (cnt_q == CNT_W'(MAX_RESULTS));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (!sts.busy || cap_hit) begin
					state_d = ST_IDLE;
				end else if (cmd.step && !sts.progress) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RUN: begin
				cmd.step = sts.busy && !cap_hit && (!sts.emit || slot_free);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.step && sts.emit) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.step && sts.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`VRBP_ASSERT_IMPL(a_no_overwrite, clk, arst_n, cmd.step && sts.emit,
		!out_valid_q || out_ready, "result register overwritten while held")
	`VRBP_ASSERT_NEXT(a_accept_run, clk, arst_n, in_valid && in_ready,
		state_q == ST_RUN && cnt_q == '0, "accepted byte did not start a run")
	`VRBP_ASSERT_NEXT(a_cap_idle, clk, arst_n, state_q == ST_RUN && cap_hit,
		state_q == ST_IDLE, "result cap did not end the run")
	`VRBP_ASSERT_IMPL(a_step_run, clk, arst_n, cmd.step,
		state_q == ST_RUN && sts.busy && !in_ready, "step issued outside a run")

endmodule

// ----- rtl/core/vector_record_bitfield_parser_unit.sv -----
// Vector record bit-field parser.
// record: one byte per transaction (data_byte, mode); mode is sampled only on
//   the first byte of a record (0 rect, 1 matrix, 2/3 colour transform, 4 rgb,
//   5 rgba); a first byte with mode 6 or 7 is dropped.
// fields: one transaction per decoded field (field_id, field_value,
//   record_last), held in an output register until taken.
// cfg: register writes (default scale, rotate, multiply, add), always ready;
//   write only while the block is idle.
// Decoding: after a byte is accepted the controller runs one decode step per
//   cycle (count width, flag, field or default) while no emitting step waits
//   for the output register; a field appears on fields in the cycle after
//   its step, and the block gives at most eight fields per byte.
// A stalled receiver holds the pending field; the next emitting step waits
//   for the output register, and record is not ready until the run ends.
// Reset clears the bit buffer, record state and output valid, and loads the
//   default registers with their reset values.
module vector_record_bitfield_parser_unit #(
	parameter int RECT_COUNT_BITS = 5,
	parameter int SCALE_COUNT_BITS = 5,
	parameter int ROTATE_COUNT_BITS = 5,
	parameter int TRANSLATE_COUNT_BITS = 5,
	parameter int COLOUR_COUNT_BITS = 4
) (
	input logic clk,
	input logic arst_n,
	vrbp_in_if.sink record,
	vrbp_out_if.source fields,
	vrbp_cfg_if.sink cfg
);
	import vrbp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	vrbp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(record.valid),
		.in_ready(record.ready),
		.out_valid(fields.valid),
		.out_ready(fields.ready),
		.cmd(cmd),
		.sts(sts)
	);

	vrbp_datapath #(
		.RECT_COUNT_BITS(RECT_COUNT_BITS),
		.SCALE_COUNT_BITS(SCALE_COUNT_BITS),
		.ROTATE_COUNT_BITS(ROTATE_COUNT_BITS),
		.TRANSLATE_COUNT_BITS(TRANSLATE_COUNT_BITS),
		.COLOUR_COUNT_BITS(COLOUR_COUNT_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.data_byte(record.data_byte),
		.mode(record.mode),
		.cfg_we(cfg.valid),
		.cfg_index(cfg.index),
		.cfg_data(cfg.data),
		.field_id(fields.field_id),
		.field_value(fields.field_value),
		.record_last(fields.record_last)
	);

endmodule

// ----- dv/vrbp_tb_pkg.sv -----
package vrbp_tb_pkg;

	typedef enum logic [2:0] {
		REC_RECT = 3'd0,
		REC_MATRIX = 3'd1,
		REC_CXFORM = 3'd2,
		REC_CXFORM_ALPHA = 3'd3,
		REC_RGB = 3'd4,
		REC_RGBA = 3'd5,
		REC_UNUSED6 = 3'd6,
		REC_UNUSED7 = 3'd7
	} record_kind_t;

	localparam int RECT_CNT_W = 5;
	localparam int SCALE_CNT_W = 5;
	localparam int ROTATE_CNT_W = 5;
	localparam int TRANSLATE_CNT_W = 5;
	localparam int COLOUR_CNT_W = 4;

	localparam int FLD_RECT_X0 = 0;
	localparam int FLD_SCALE_X = 4;
	localparam int FLD_SCALE_Y = 5;
	localparam int FLD_ROTATE_0 = 6;
	localparam int FLD_ROTATE_1 = 7;
	localparam int FLD_TRANSLATE_X = 8;
	localparam int FLD_TRANSLATE_Y = 9;
	localparam int FLD_MUL_R = 10;
	localparam int FLD_COLOUR_R = 18;

	typedef struct packed {
		logic [vrbp_pkg::ID_W-1:0] id;
		logic [vrbp_pkg::VAL_W-1:0] value;
		logic last;
	} field_t;

endpackage

// ----- dv/vrbp_field_checker.sv -----
module vrbp_field_checker
	import vrbp_pkg::*;
	import vrbp_tb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	vrbp_in_if rec_ch,
	vrbp_out_if fld_ch,
	vrbp_cfg_if cfg_ch,
	output int mismatches,
	output int fields_owed,
	output logic record_open
);
	timeunit 1ns;
	timeprecision 1ps;

	field_t owed_fields[$];

	logic [39:0] pool;
	int pool_bits;
	int step;
	int width;
	record_kind_t kind;
	logic with_mul;
	logic with_add;
	logic [VAL_W-1:0] dflt_scale;
	logic [VAL_W-1:0] dflt_rotate;
	logic [VAL_W-1:0] dflt_mul;
	logic [VAL_W-1:0] dflt_add;
	int produced;

	function automatic logic [39:0] pool_mask(int w);
		return (w >= 40) ? '1 : ((40'd1 << w) - 40'd1);
	endfunction

	function automatic logic [VAL_W-1:0] take(int w, bit sgn);
		logic [39:0] v;
		if (w == 0)
			return '0;
		v = (pool >> (pool_bits - w)) & pool_mask(w);
		pool_bits = pool_bits - w;
		pool = pool & pool_mask(pool_bits);
		if (sgn && v[w-1])
			v = v | ~pool_mask(w);
		return v[VAL_W-1:0];
	endfunction

	function automatic void emit(int id, logic [VAL_W-1:0] value, bit last, int next);
		field_t f;
		f.id = id[ID_W-1:0];
		f.value = value;
		f.last = last;
		owed_fields.push_back(f);
		produced++;
		if (last) begin
			step = 0;
			pool = '0;
			pool_bits = 0;
		end else begin
			step = next;
		end
	endfunction

	function automatic bit fetch_width(int cnt_bits, int next);
		if (pool_bits < cnt_bits)
			return 1'b0;
		width = int'(take(cnt_bits, 1'b0));
		step = next;
		return 1'b1;
	endfunction

	function automatic bit fetch_field(int id, int w, bit sgn, bit last, int next);
		if (pool_bits < w)
			return 1'b0;
		emit(id, take(w, sgn), last, next);
		return 1'b1;
	endfunction

	function automatic bit branch(int present_step, int absent_step);
		logic [VAL_W-1:0] flag;
		if (pool_bits < 1)
			return 1'b0;
		flag = take(1, 1'b0);
		step = flag[0] ? present_step : absent_step;
		return 1'b1;
	endfunction

	function automatic bit advance();
		logic [VAL_W-1:0] flags;
		logic [VAL_W-1:0] dflt;
		bit grp;
		bit alpha;
		int terms;
		case (kind)
			REC_RECT: begin
				if (step == 1)
					return fetch_width(RECT_CNT_W, 2);
				if (step >= 2 && step <= 5)
					return fetch_field(FLD_RECT_X0 + step - 2, width, 1'b1, step == 5, step + 1);
			end
			REC_MATRIX: begin
				case (step)
					1: return branch(2, 12);
					2: return fetch_width(SCALE_CNT_W, 3);
					3: return fetch_field(FLD_SCALE_X, width, 1'b1, 1'b0, 4);
					4: return fetch_field(FLD_SCALE_Y, width, 1'b1, 1'b0, 5);
					5: return branch(6, 14);
					6: return fetch_width(ROTATE_CNT_W, 7);
					7: return fetch_field(FLD_ROTATE_0, width, 1'b1, 1'b0, 8);
					8: return fetch_field(FLD_ROTATE_1, width, 1'b1, 1'b0, 9);
					9: return fetch_width(TRANSLATE_CNT_W, 10);
					10: return fetch_field(FLD_TRANSLATE_X, width, 1'b1, 1'b0, 11);
					11: return fetch_field(FLD_TRANSLATE_Y, width, 1'b1, 1'b1, 0);
					12: begin
						emit(FLD_SCALE_X, dflt_scale, 1'b0, 13);
						return 1'b1;
					end
					13: begin
						emit(FLD_SCALE_Y, dflt_scale, 1'b0, 5);
						return 1'b1;
					end
					14: begin
						emit(FLD_ROTATE_0, dflt_rotate, 1'b0, 15);
						return 1'b1;
					end
					15: begin
						emit(FLD_ROTATE_1, dflt_rotate, 1'b0, 9);
						return 1'b1;
					end
					default: ;
				endcase
			end
			REC_CXFORM, REC_CXFORM_ALPHA: begin
				if (step == 1) begin
					if (pool_bits < 2)
						return 1'b0;
					flags = take(2, 1'b0);
					with_add = flags[1];
					with_mul = flags[0];
					step = 2;
					return 1'b1;
				end
				if (step == 2)
					return fetch_width(COLOUR_CNT_W, 3);
				if (step >= 3 && step <= 10) begin
					grp = (step < 7) ? with_mul : with_add;
					alpha = (step == 6) || (step == 10);
					dflt = (step < 7) ? dflt_mul : dflt_add;
					// alpha terms come from the stream only in the alpha variant
					if (grp && (!alpha || kind == REC_CXFORM_ALPHA))
						return fetch_field(FLD_MUL_R + step - 3, width, 1'b1, step == 10,
							step + 1);
					emit(FLD_MUL_R + step - 3, dflt, step == 10, step + 1);
					return 1'b1;
				end
			end
			REC_RGB, REC_RGBA: begin
				terms = (kind == REC_RGBA) ? 4 : 3;
				if (step >= 1 && step <= terms)
					return fetch_field(FLD_COLOUR_R + step - 1, 8, 1'b0, step == terms, step + 1);
			end
			default: ;
		endcase
		step = 0;
		pool = '0;
		pool_bits = 0;
		return 1'b0;
	endfunction

	function automatic void decode_byte(logic [DATA_W-1:0] value, logic [MODE_W-1:0] code);
		if (step == 0) begin
			// drop a record start with an unknown kind
			if (code > REC_RGBA)
				return;
			kind = record_kind_t'(code);
			step = 1;
			width = 0;
			with_mul = 1'b0;
			with_add = 1'b0;
			pool = '0;
			pool_bits = 0;
		end
		pool = {pool[31:0], value};
		pool_bits = pool_bits + 8;
		if (pool_bits > 40)
			pool_bits = 40;
		produced = 0;
		while (step != 0 && produced < MAX_RESULTS) begin
			if (!advance())
				break;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_t want;
		if (!arst_n) begin
			owed_fields.delete();
			pool = '0;
			pool_bits = 0;
			step = 0;
			width = 0;
			kind = REC_RECT;
			with_mul = 1'b0;
			with_add = 1'b0;
			dflt_scale = 31'd65536;
			dflt_rotate = 31'd0;
			dflt_mul = 31'd256;
			dflt_add = 31'd0;
			mismatches = 0;
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_DEFAULT_SCALE: dflt_scale = cfg_ch.data;
					REG_DEFAULT_ROTATE: dflt_rotate = cfg_ch.data;
					REG_DEFAULT_MULTIPLY: dflt_mul = cfg_ch.data;
					REG_DEFAULT_ADD: dflt_add = cfg_ch.data;
					default: ;
				endcase
			end
			if (rec_ch.valid && rec_ch.ready)
				decode_byte(rec_ch.data_byte, rec_ch.mode);
			if (fld_ch.valid && fld_ch.ready) begin
				if (owed_fields.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected field transaction: id %0d value %0d last %0b",
							fld_ch.field_id, fld_ch.field_value, fld_ch.record_last);
				end else begin
					want = owed_fields.pop_front();
					if (want.id !== fld_ch.field_id || want.value !== fld_ch.field_value ||
							want.last !== fld_ch.record_last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("field mismatch: expected id %0d value %0d last %0b, got id %0d value %0d last %0b",
								want.id, $signed(want.value), want.last,
								fld_ch.field_id, fld_ch.field_value, fld_ch.record_last);
					end
				end
			end
		end
		fields_owed = owed_fields.size();
		record_open = (step != 0);
	end

endmodule

// ----- dv/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import vrbp_pkg::*;
	import vrbp_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 20;

	typedef enum {
		SHAPE_RANDOM,
		SHAPE_ABSENT,
		SHAPE_ZERO,
		SHAPE_FULL,
		SHAPE_WIDEST
	} shape_t;

	typedef enum {
		FLOW_FREE,
		FLOW_CHOPPY,
		FLOW_SPARSE
	} flow_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vrbp_in_if rec_if();
	vrbp_out_if fld_if();
	vrbp_cfg_if cfg_if();

	int mismatches;
	int fields_owed;
	logic record_open;

	int items_sent = 0;
	int burst_left = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	flow_t flow = FLOW_FREE;
	int flow_left = 0;
	int idle_cycles = 0;
	bit record_bits[$];

	vector_record_bitfield_parser_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.record(rec_if),
		.fields(fld_if),
		.cfg(cfg_if)
	);

	vrbp_field_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.rec_ch(rec_if),
		.fld_ch(fld_if),
		.cfg_ch(cfg_if),
		.mismatches(mismatches),
		.fields_owed(fields_owed),
		.record_open(record_open)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (rec_if.valid && rec_if.ready) || (fld_if.valid && fld_if.ready) ||
				(cfg_if.valid && cfg_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		fld_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				fld_if.ready <= 1'b0;
			end else if (holds_served != hold_requests) begin
				holds_served++;
				hold_left = LONG_HOLD;
				fld_if.ready <= 1'b0;
			end else begin
				if (flow_left == 0) begin
					flow = flow_t'($urandom_range(0, 2));
					flow_left = $urandom_range(20, 150);
				end
				flow_left--;
				case (flow)
					FLOW_FREE: fld_if.ready <= 1'b1;
					FLOW_CHOPPY: fld_if.ready <= 1'($urandom_range(0, 1));
					default: fld_if.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic send_byte(input logic [DATA_W-1:0] value, input logic [MODE_W-1:0] code);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				rec_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		rec_if.valid <= 1'b1;
		rec_if.data_byte <= value;
		rec_if.mode <= code;
		do
			@(posedge clk);
		while (!(rec_if.valid && rec_if.ready));
		@(negedge clk);
		burst_left--;
		items_sent++;
	endtask

	function automatic logic [31:0] pick_value(int w);
		logic [31:0] ones;
		if (w == 0)
			return '0;
		ones = (32'd1 << w) - 32'd1;
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ones;
			2: return 32'd1 << (w - 1);
			3: return ones >> 1;
			default: return $urandom & ones;
		endcase
	endfunction

	function automatic int pick_width(int cnt_bits, shape_t shape);
		int widest;
		int r;
		widest = (1 << cnt_bits) - 1;
		case (shape)
			SHAPE_ABSENT, SHAPE_ZERO: return 0;
			SHAPE_WIDEST: return widest;
			SHAPE_FULL: return $urandom_range(1, 4);
			default: begin
				r = $urandom_range(0, 15);
				if (r == 0)
					return 0;
				if (r == 1)
					return widest;
				return $urandom_range(1, (widest < 10) ? widest : 10);
			end
		endcase
	endfunction

	function automatic bit pick_flag(shape_t shape);
		if (shape == SHAPE_ABSENT)
			return 1'b0;
		if (shape == SHAPE_RANDOM)
			return 1'($urandom_range(0, 1));
		return 1'b1;
	endfunction

	function automatic void append_bits(logic [31:0] value, int w);
		for (int i = w - 1; i >= 0; i--)
			record_bits.push_back(value[i]);
	endfunction

	task automatic send_record(input record_kind_t kind, input shape_t shape, input bit broken);
		int w;
		int terms;
		int nbytes;
		int keep;
		bit on;
		bit add_on;
		bit mul_on;
		logic [DATA_W-1:0] b;
		record_bits.delete();
		case (kind)
			REC_RECT: begin
				w = pick_width(RECT_CNT_W, shape);
				append_bits(w, RECT_CNT_W);
				repeat (4) append_bits(pick_value(w), w);
			end
			REC_MATRIX: begin
				on = pick_flag(shape);
				append_bits(32'(on), 1);
				if (on) begin
					w = pick_width(SCALE_CNT_W, shape);
					append_bits(w, SCALE_CNT_W);
					repeat (2) append_bits(pick_value(w), w);
				end
				on = pick_flag(shape);
				append_bits(32'(on), 1);
				if (on) begin
					w = pick_width(ROTATE_CNT_W, shape);
					append_bits(w, ROTATE_CNT_W);
					repeat (2) append_bits(pick_value(w), w);
				end
				w = pick_width(TRANSLATE_CNT_W, shape);
				append_bits(w, TRANSLATE_CNT_W);
				repeat (2) append_bits(pick_value(w), w);
			end
			REC_CXFORM, REC_CXFORM_ALPHA: begin
				add_on = pick_flag(shape);
				mul_on = pick_flag(shape);
				append_bits(32'(add_on), 1);
				append_bits(32'(mul_on), 1);
				w = pick_width(COLOUR_CNT_W, shape);
				append_bits(w, COLOUR_CNT_W);
				terms = (kind == REC_CXFORM_ALPHA) ? 4 : 3;
				if (mul_on)
					repeat (terms) append_bits(pick_value(w), w);
				if (add_on)
					repeat (terms) append_bits(pick_value(w), w);
			end
			default: begin
				repeat ((kind == REC_RGBA) ? 4 : 3) append_bits($urandom_range(0, 255), 8);
			end
		endcase
		nbytes = (record_bits.size() + 7) / 8;
		keep = broken ? $urandom_range(1, nbytes) : nbytes;
		for (int i = 0; i < keep; i++) begin
			// pad the tail with random bits
			for (int j = 0; j < 8; j++)
				b = {b[6:0], (record_bits.size() != 0) ? record_bits.pop_front() :
					1'($urandom_range(0, 1))};
			send_byte(b, (i == 0) ? kind : 3'($urandom_range(0, 7)));
		end
	endtask

	task automatic run_traffic(input int count);
		int target;
		int pick;
		target = items_sent + count;
		while (items_sent < target) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				send_byte(8'($urandom), 3'($urandom_range(0, 7)));
			else
				send_record(record_kind_t'($urandom_range(0, 5)), SHAPE_RANDOM, pick < 3);
		end
	endtask

	task automatic settle();
		while (record_open)
			send_byte(8'($urandom), 3'($urandom_range(0, 7)));
		rec_if.valid <= 1'b0;
		while (fields_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do
			@(posedge clk);
		while (!(cfg_if.valid && cfg_if.ready));
		@(negedge clk);
	endtask

	task automatic write_defaults(input logic [VAL_W-1:0] scale, input logic [VAL_W-1:0] rotate,
			input logic [VAL_W-1:0] mul, input logic [VAL_W-1:0] add);
		put_reg(REG_DEFAULT_SCALE, scale);
		put_reg(REG_DEFAULT_ROTATE, rotate);
		put_reg(REG_DEFAULT_MULTIPLY, mul);
		put_reg(REG_DEFAULT_ADD, add);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		rec_if.valid = 1'b0;
		rec_if.data_byte = '0;
		rec_if.mode = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		send_record(REC_RECT, SHAPE_ZERO, 1'b0);
		send_record(REC_MATRIX, SHAPE_ABSENT, 1'b0);
		send_record(REC_MATRIX, SHAPE_ZERO, 1'b0);
		send_record(REC_CXFORM, SHAPE_ZERO, 1'b0);
		send_record(REC_CXFORM_ALPHA, SHAPE_ABSENT, 1'b0);
		send_record(REC_CXFORM, SHAPE_FULL, 1'b0);
		send_record(REC_CXFORM_ALPHA, SHAPE_FULL, 1'b0);
		send_byte(8'hFF, REC_UNUSED6);
		send_byte(8'h00, REC_UNUSED7);
		send_byte(8'h00, REC_RGB);
		send_byte(8'hFF, REC_UNUSED7);
		send_byte(8'h5A, REC_RECT);
		send_byte(8'hA5, REC_RGBA);
		send_byte(8'h01, REC_UNUSED6);
		send_byte(8'h80, REC_MATRIX);
		send_byte(8'h7F, REC_RGB);
		settle();

		write_defaults(31'h4000_0000, 31'h3FFF_FFFF, 31'h0, 31'h7FFF_FFFF);
		run_traffic(30);
		settle();

		write_defaults(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
		hold_requests <= hold_requests + 1;
		send_record(REC_RECT, SHAPE_WIDEST, 1'b0);
		run_traffic(30);
		settle();

		write_defaults(31'h3FFF_FFFF, 31'h4000_0000, 31'h4000_0000, 31'h3FFF_FFFF);
		run_traffic(25);
		rec_if.valid <= 1'b0;
		while (fields_owed != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && fields_owed == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/vrbp_pkg.sv
rtl/core/vrbp_if.sv
rtl/core/vrbp_datapath.sv
rtl/core/vrbp_ctrl.sv
rtl/core/vector_record_bitfield_parser_unit.sv
dv/vrbp_tb_pkg.sv
dv/vrbp_field_checker.sv
dv/testbench.sv
